FILE: rtl/rgba_rect_fill_blend_engine_assert.svh
// Assertion macros for the RGBA rectangle fill and blend engine.
// Each macro samples on the rising edge of clock and is disabled while reset is high.
`ifndef RGBA_RECT_FILL_BLEND_ENGINE_ASSERT_SVH
`define RGBA_RECT_FILL_BLEND_ENGINE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent
`define RRFB_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define RRFB_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/rrfb_pkg.sv
// Shared constants, command codes and control structs of the fill and blend engine.
// Used by the sequencer, blend and top-level RTL files; depends on nothing.
`default_nettype none

package rrfb_pkg;

   // Frame store geometry
   localparam int MAX_WIDTH  = 64;
   localparam int MAX_HEIGHT = 64;
   localparam int X_BITS     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int Y_BITS     = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int XC_BITS    = $clog2(MAX_WIDTH + 1);
   localparam int YC_BITS    = $clog2(MAX_HEIGHT + 1);
   localparam int FB_DEPTH   = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_BITS  = (FB_DEPTH > 1) ? $clog2(FB_DEPTH) : 1;

   // Field widths
   localparam int PIXEL_BITS     = 32;
   localparam int CHAN_BITS      = 8;
   localparam int COORD_BITS     = 16;
   localparam int CMD_BITS       = 2;
   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = 7;

   // Command codes
   localparam logic [CMD_BITS-1:0] CMD_CLEAR = 2'd0;
   localparam logic [CMD_BITS-1:0] CMD_FILL  = 2'd1;
   localparam logic [CMD_BITS-1:0] CMD_BLEND = 2'd2;
   localparam logic [CMD_BITS-1:0] CMD_READ  = 2'd3;

   // Register indexes and reset values
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_WIDTH  = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_HEIGHT = 1'b1;
   localparam logic [CSR_DATA_BITS-1:0]  FRAME_RESET      = 7'd64;

   // Blend arithmetic
   localparam logic [CHAN_BITS-1:0] ALPHA_MAX   = 8'd255;
   localparam int                   BLEND_SHIFT = 8;

   // Frame store port controls from the sequencer
   typedef struct packed {
      logic                  rd_en;
      logic [ADDR_BITS-1:0]  rd_addr;
      logic                  wr_en;
      logic [ADDR_BITS-1:0]  wr_addr;
      logic                  blend;
      logic [PIXEL_BITS-1:0] fill_px;
   } ram_ctl_type;

   // Result handover from the sequencer
   typedef struct packed {
      logic load;
      logic in_frame;
   } res_ctl_type;

endpackage

`default_nettype wire

FILE: rtl/rrfb_ram.sv
// Generic single-clock RAM: one write port, one read port with registered read data.
// Stand-alone; no package dependency.
`default_nettype none

module rrfb_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  wire logic                       clock,
   input  wire logic                       wr_en,
   input  wire logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  wire logic [WIDTH-1:0]           wr_data,
   input  wire logic                       rd_en,
   input  wire logic [$clog2(DEPTH)-1:0]   rd_addr,
   output logic      [WIDTH-1:0]           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port: hold the last read word until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: rtl/rrfb_blend.sv
// Per-channel alpha blend of a source colour over a stored pixel.
// Depends on rrfb_pkg for channel widths and the blend constants.
`default_nettype none

module rrfb_blend (
   input  wire logic [rrfb_pkg::PIXEL_BITS-1:0] src_px,
   input  wire logic [rrfb_pkg::PIXEL_BITS-1:0] dst_px,
   output logic      [rrfb_pkg::PIXEL_BITS-1:0] blend_px
);

   localparam int CB = rrfb_pkg::CHAN_BITS;
   localparam int NCH = rrfb_pkg::PIXEL_BITS / CB;
   localparam int PIXEL_TOP = rrfb_pkg::PIXEL_BITS - 1;

   logic [CB-1:0]   alpha;
   logic [CB-1:0]   inv_alpha;
   logic [2*CB:0]   sum [NCH];

   // Source alpha is both a channel and the weight
   assign alpha     = src_px[PIXEL_TOP -: CB];
   assign inv_alpha = rrfb_pkg::ALPHA_MAX - alpha;

   // Weighted sum per channel, keep the high byte
   always_comb begin
      for (int c = 0; c < NCH; c++) begin
         sum[c] = (2*CB+1)'((2*CB)'(src_px[c*CB +: CB]) * (2*CB)'(alpha))
                + (2*CB+1)'((2*CB)'(dst_px[c*CB +: CB]) * (2*CB)'(inv_alpha));
         blend_px[c*CB +: CB] = sum[c][rrfb_pkg::BLEND_SHIFT +: CB];
      end
   end

endmodule

`default_nettype wire

FILE: rtl/rrfb_ctrl.sv
// Command sequencer: configuration registers, clipping, pixel walk and the
// frame store clearing pass after reset. Depends on rrfb_pkg.
`default_nettype none

module rrfb_ctrl (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_ready,
   input  wire logic [rrfb_pkg::CMD_BITS-1:0]         req_command,
   input  wire logic signed [rrfb_pkg::COORD_BITS-1:0] req_pos_x,
   input  wire logic signed [rrfb_pkg::COORD_BITS-1:0] req_pos_y,
   input  wire logic signed [rrfb_pkg::COORD_BITS-1:0] req_rect_w,
   input  wire logic signed [rrfb_pkg::COORD_BITS-1:0] req_rect_h,
   input  wire logic [rrfb_pkg::CHAN_BITS-1:0]        req_color_red,
   input  wire logic [rrfb_pkg::CHAN_BITS-1:0]        req_color_green,
   input  wire logic [rrfb_pkg::CHAN_BITS-1:0]        req_color_blue,
   input  wire logic [rrfb_pkg::CHAN_BITS-1:0]        req_color_alpha,
   input  wire logic                                  csr_wr_en,
   input  wire logic [rrfb_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  wire logic [rrfb_pkg::CSR_DATA_BITS-1:0]    csr_wdata,
   input  wire logic                                  rsp_free,
   output rrfb_pkg::ram_ctl_type                      ram_ctl,
   output rrfb_pkg::res_ctl_type                      res_ctl
);

   localparam int AB  = rrfb_pkg::ADDR_BITS;
   localparam int XB  = rrfb_pkg::X_BITS;
   localparam int YB  = rrfb_pkg::Y_BITS;
   localparam int XCB = rrfb_pkg::XC_BITS;
   localparam int YCB = rrfb_pkg::YC_BITS;
   localparam int DB  = rrfb_pkg::CSR_DATA_BITS;
   localparam int CW  = rrfb_pkg::COORD_BITS + 2;

   localparam logic [2:0] ST_INIT  = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_SETUP = 3'd2;
   localparam logic [2:0] ST_WALK  = 3'd3;
   localparam logic [2:0] ST_DRAIN = 3'd4;
   localparam logic [2:0] ST_RDATA = 3'd5;
   localparam logic [2:0] ST_RESP  = 3'd6;

   // Control registers
   logic [2:0]    state_ff, state_in;
   logic [AB-1:0] init_cnt_ff, init_cnt_in;
   logic          wr_valid_ff, wr_valid_in;
   logic [AB-1:0] wr_addr_ff, wr_addr_in;
   logic          blend_ff;
   logic [rrfb_pkg::PIXEL_BITS-1:0] fill_px_ff;
   logic [DB-1:0] fw_ff, fh_ff;

   // Command and walk registers
   logic [rrfb_pkg::CMD_BITS-1:0]          cmd_ff;
   logic signed [rrfb_pkg::COORD_BITS-1:0] x_ff, y_ff, w_ff, h_ff;
   logic [XB-1:0]  cx_ff, cx_in, x0_ff, x0_in;
   logic [YB-1:0]  cy_ff, cy_in;
   logic [XCB-1:0] x1_ff, x1_in;
   logic [YCB-1:0] y1_ff, y1_in;
   logic [AB-1:0]  row_base_ff, row_base_in;
   logic           in_frame_ff, in_frame_in;

   // Setup arithmetic
   logic [DB-1:0]        eff_w, eff_h;
   logic signed [CW-1:0] xs, ys, xe, ye, fws, fhs;
   logic signed [CW-1:0] x0s, y0s, x1s, y1s;
   logic                 read_hit, fill_empty, accept;
   logic [AB-1:0]        read_addr, walk_addr;
   logic                 last_col, last_row;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE);

   // Clip the rectangle to the visible frame
   always_comb begin
      eff_w = (32'(fw_ff) > 32'(rrfb_pkg::MAX_WIDTH))  ? DB'(rrfb_pkg::MAX_WIDTH)  : fw_ff;
      eff_h = (32'(fh_ff) > 32'(rrfb_pkg::MAX_HEIGHT)) ? DB'(rrfb_pkg::MAX_HEIGHT) : fh_ff;
      fws   = $signed(CW'(eff_w));
      fhs   = $signed(CW'(eff_h));
      xs    = CW'(x_ff);
      ys    = CW'(y_ff);
      xe    = xs + CW'(w_ff);
      ye    = ys + CW'(h_ff);
      if (cmd_ff == rrfb_pkg::CMD_CLEAR) begin
         x0s = '0;
         y0s = '0;
         x1s = fws;
         y1s = fhs;
      end else begin
         x0s = (xs > 0) ? xs : '0;
         y0s = (ys > 0) ? ys : '0;
         x1s = (xe < fws) ? xe : fws;
         y1s = (ye < fhs) ? ye : fhs;
      end
      fill_empty = (eff_w == '0) || (eff_h == '0)
                || ((cmd_ff != rrfb_pkg::CMD_CLEAR)
                    && ((w_ff <= 16'sd0) || (h_ff <= 16'sd0)
                        || ((cmd_ff == rrfb_pkg::CMD_BLEND) && (fill_px_ff[31:24] == '0))
                        || (x0s >= x1s) || (y0s >= y1s)));
      read_hit  = (xs >= 0) && (ys >= 0) && (xs < fws) && (ys < fhs);
      read_addr = AB'(AB'(y_ff[YB-1:0]) * AB'(rrfb_pkg::MAX_WIDTH)) + AB'(x_ff[XB-1:0]);
      walk_addr = row_base_ff + AB'(cx_ff);
      last_col  = ((XCB'(cx_ff) + XCB'(1)) == x1_ff);
      last_row  = ((YCB'(cy_ff) + YCB'(1)) == y1_ff);
   end

   // Sequencer next state
   always_comb begin
      state_in    = state_ff;
      init_cnt_in = init_cnt_ff;
      wr_valid_in = 1'b0;
      wr_addr_in  = wr_addr_ff;
      cx_in       = cx_ff;
      cy_in       = cy_ff;
      x0_in       = x0_ff;
      x1_in       = x1_ff;
      y1_in       = y1_ff;
      row_base_in = row_base_ff;
      in_frame_in = in_frame_ff;
      case (state_ff)
         ST_INIT: begin
            wr_valid_in = 1'b1;
            wr_addr_in  = init_cnt_ff;
            init_cnt_in = init_cnt_ff + AB'(1);
            if (init_cnt_ff == AB'(rrfb_pkg::FB_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            if (cmd_ff == rrfb_pkg::CMD_READ) begin
               in_frame_in = read_hit;
               state_in    = read_hit ? ST_RDATA : ST_RESP;
            end else begin
               in_frame_in = 1'b0;
               if (fill_empty) begin
                  state_in = ST_RESP;
               end else begin
                  x0_in       = XB'(x0s);
                  cx_in       = XB'(x0s);
                  cy_in       = YB'(y0s);
                  x1_in       = XCB'(x1s);
                  y1_in       = YCB'(y1s);
                  row_base_in = AB'(AB'(YB'(y0s)) * AB'(rrfb_pkg::MAX_WIDTH));
                  state_in    = ST_WALK;
               end
            end
         end
         ST_WALK: begin
            // Issue one pixel; it is written back in the following cycle
            wr_valid_in = 1'b1;
            wr_addr_in  = walk_addr;
            if (last_col) begin
               cx_in = x0_ff;
               if (last_row) begin
                  state_in = ST_DRAIN;
               end else begin
                  cy_in       = cy_ff + YB'(1);
                  row_base_in = row_base_ff + AB'(rrfb_pkg::MAX_WIDTH);
               end
            end else begin
               cx_in = cx_ff + XB'(1);
            end
         end
         ST_DRAIN: begin
            state_in = ST_RESP;
         end
         ST_RDATA: begin
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_INIT;
         init_cnt_ff <= '0;
         wr_valid_ff <= 1'b0;
         blend_ff    <= 1'b0;
         fill_px_ff  <= '0;
         fw_ff       <= rrfb_pkg::FRAME_RESET;
         fh_ff       <= rrfb_pkg::FRAME_RESET;
      end else begin
         state_ff    <= state_in;
         init_cnt_ff <= init_cnt_in;
         wr_valid_ff <= wr_valid_in;
         if (accept) begin
            fill_px_ff <= {req_color_alpha, req_color_blue, req_color_green, req_color_red};
            blend_ff   <= (req_command == rrfb_pkg::CMD_BLEND)
                       && (req_color_alpha != rrfb_pkg::ALPHA_MAX);
         end
         if (csr_wr_en) begin
            case (csr_index)
               rrfb_pkg::CSR_FRAME_WIDTH:  fw_ff <= csr_wdata;
               rrfb_pkg::CSR_FRAME_HEIGHT: fh_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   // Command fields and walk payload
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff <= req_command;
         x_ff   <= req_pos_x;
         y_ff   <= req_pos_y;
         w_ff   <= req_rect_w;
         h_ff   <= req_rect_h;
      end
      wr_addr_ff  <= wr_addr_in;
      cx_ff       <= cx_in;
      cy_ff       <= cy_in;
      x0_ff       <= x0_in;
      x1_ff       <= x1_in;
      y1_ff       <= y1_in;
      row_base_ff <= row_base_in;
      in_frame_ff <= in_frame_in;
   end

   // Frame store controls
   always_comb begin
      ram_ctl.rd_en   = ((state_ff == ST_SETUP) && (cmd_ff == rrfb_pkg::CMD_READ) && read_hit)
                     || ((state_ff == ST_WALK) && blend_ff);
      ram_ctl.rd_addr = (state_ff == ST_WALK) ? walk_addr : read_addr;
      ram_ctl.wr_en   = wr_valid_ff;
      ram_ctl.wr_addr = wr_addr_ff;
      ram_ctl.blend   = blend_ff;
      ram_ctl.fill_px = fill_px_ff;
   end

   // Hand the result over when the output slot is free
   assign res_ctl.load     = (state_ff == ST_RESP) && rsp_free;
   assign res_ctl.in_frame = in_frame_ff;

endmodule

`default_nettype wire

FILE: rtl/rgba_rect_fill_blend_engine.sv
// RGBA rectangle fill and blend engine: clear, opaque fill, alpha fill and
// pixel read over a 64 by 64 frame store held in a single-port-pair RAM.
//
// Usage:
//  - req_* is a valid/ready command channel; rsp_* returns exactly one result
//    per command, with pixel data and read_in_frame set only for a read.
//  - csr_wr_en/csr_index/csr_wdata write frame_width (0) and frame_height (1);
//    write them only while no command is in flight.
//  - After reset a clearing pass zeroes all 4096 pixels of the frame store
//    (one pixel per cycle); req_ready stays low until it ends.
//  - Steps after acceptance: a read inside the frame runs setup, frame store
//    read, result; a read outside it or a fill that clips to nothing runs
//    setup, result; a fill or clear runs setup, pixel walk, drain, result.
//  - Throughput: one pixel per cycle, set by the frame store's write port; an
//    alpha fill reads each pixel in the cycle before its write-back.
//  - One command is worked on at a time; the next can be taken once
//    the result has moved into the output register.
//  - If the receiver stalls, the result waits in the output register; a second
//    finished result waits in the sequencer and the block takes no command.
`default_nettype none

module rgba_rect_fill_blend_engine (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_valid,
   output logic                                        req_ready,
   input  wire logic [rrfb_pkg::CMD_BITS-1:0]          req_command,
   input  wire logic signed [rrfb_pkg::COORD_BITS-1:0] req_pos_x,
   input  wire logic signed [rrfb_pkg::COORD_BITS-1:0] req_pos_y,
   input  wire logic signed [rrfb_pkg::COORD_BITS-1:0] req_rect_w,
   input  wire logic signed [rrfb_pkg::COORD_BITS-1:0] req_rect_h,
   input  wire logic [rrfb_pkg::CHAN_BITS-1:0]         req_color_red,
   input  wire logic [rrfb_pkg::CHAN_BITS-1:0]         req_color_green,
   input  wire logic [rrfb_pkg::CHAN_BITS-1:0]         req_color_blue,
   input  wire logic [rrfb_pkg::CHAN_BITS-1:0]         req_color_alpha,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_ready,
   output logic [rrfb_pkg::CHAN_BITS-1:0]              rsp_pixel_red,
   output logic [rrfb_pkg::CHAN_BITS-1:0]              rsp_pixel_green,
   output logic [rrfb_pkg::CHAN_BITS-1:0]              rsp_pixel_blue,
   output logic [rrfb_pkg::CHAN_BITS-1:0]              rsp_pixel_alpha,
   output logic                                        rsp_read_in_frame,
   input  wire logic                                   csr_wr_en,
   input  wire logic [rrfb_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  wire logic [rrfb_pkg::CSR_DATA_BITS-1:0]     csr_wdata
);

   localparam int CB = rrfb_pkg::CHAN_BITS;

   rrfb_pkg::ram_ctl_type ram_ctl;
   rrfb_pkg::res_ctl_type res_ctl;

   logic [rrfb_pkg::PIXEL_BITS-1:0] rd_data;
   logic [rrfb_pkg::PIXEL_BITS-1:0] blend_px;
   logic [rrfb_pkg::PIXEL_BITS-1:0] wr_data;
   logic                            rsp_free;

   logic                            rsp_valid_ff, rsp_valid_in;
   logic [rrfb_pkg::PIXEL_BITS-1:0] rsp_px_ff, rsp_px_in;
   logic                            rsp_hit_ff, rsp_hit_in;

   assign rsp_free = !rsp_valid_ff || rsp_ready;

   // Sequencer
   rrfb_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_command     (req_command),
      .req_pos_x       (req_pos_x),
      .req_pos_y       (req_pos_y),
      .req_rect_w      (req_rect_w),
      .req_rect_h      (req_rect_h),
      .req_color_red   (req_color_red),
      .req_color_green (req_color_green),
      .req_color_blue  (req_color_blue),
      .req_color_alpha (req_color_alpha),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .rsp_free        (rsp_free),
      .ram_ctl         (ram_ctl),
      .res_ctl         (res_ctl)
   );

   // Blend the read-back pixel with the source colour
   rrfb_blend u_blend (
      .src_px   (ram_ctl.fill_px),
      .dst_px   (rd_data),
      .blend_px (blend_px)
   );

   assign wr_data = ram_ctl.blend ? blend_px : ram_ctl.fill_px;

   // Frame store
   rrfb_ram #(
      .WIDTH (rrfb_pkg::PIXEL_BITS),
      .DEPTH (rrfb_pkg::FB_DEPTH)
   ) u_frame_ram (
      .clock   (clock),
      .wr_en   (ram_ctl.wr_en),
      .wr_addr (ram_ctl.wr_addr),
      .wr_data (wr_data),
      .rd_en   (ram_ctl.rd_en),
      .rd_addr (ram_ctl.rd_addr),
      .rd_data (rd_data)
   );

   // Output register: load on handover, drop when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_px_in    = rsp_px_ff;
      rsp_hit_in   = rsp_hit_ff;
      if (res_ctl.load) begin
         rsp_valid_in = 1'b1;
         rsp_px_in    = res_ctl.in_frame ? rd_data : '0;
         rsp_hit_in   = res_ctl.in_frame;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_px_ff  <= rsp_px_in;
      rsp_hit_ff <= rsp_hit_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_pixel_red     = rsp_px_ff[0*CB +: CB];
   assign rsp_pixel_green   = rsp_px_ff[1*CB +: CB];
   assign rsp_pixel_blue    = rsp_px_ff[2*CB +: CB];
   assign rsp_pixel_alpha   = rsp_px_ff[3*CB +: CB];
   assign rsp_read_in_frame = rsp_hit_ff;

`include "rgba_rect_fill_blend_engine_assert.svh"

   // A read never targets the pixel being written back in the same cycle
   `RRFB_ASSERT_SAME(a_no_rw_overlap, ram_ctl.rd_en && ram_ctl.wr_en, ram_ctl.rd_addr != ram_ctl.wr_addr, "frame store read and write hit the same pixel")
   // A result is handed over only into a free output slot
   `RRFB_ASSERT_SAME(a_load_free, res_ctl.load, !rsp_valid_ff || rsp_ready, "result loaded over an untaken result")
   // Handover always leaves a valid result in the output register
   `RRFB_ASSERT_NEXT(a_load_valid, res_ctl.load, rsp_valid_ff, "handed-over result not shown")
   // No command is taken while a result is being handed over
   `RRFB_ASSERT_SAME(a_load_not_ready, res_ctl.load, !req_ready, "command accepted during result handover")

endmodule

`default_nettype wire
